/* design/ansi_escape_command_decoder_top_assert.svh */
// assertion macros shared by the checker of the escape command decoder
`ifndef ANSI_ESCAPE_COMMAND_DECODER_TOP_ASSERT_SVH
`define ANSI_ESCAPE_COMMAND_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define AECD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define AECD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/aecd_pkg.sv */
// types, codes and lookup functions of the escape command decoder
`timescale 1ns / 1ps

package aecd_pkg;

  localparam int ACCUM_W = 14;
  localparam int POS_W   = 15;
  localparam int PADDR_W = 3;

  localparam logic REG_SCREEN_WIDTH = 1'b0;
  localparam logic [7:0] SCREEN_WIDTH_RESET = 8'd80;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_Z     = 8'h5A;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_Z     = 8'h7A;
  localparam logic [7:0] CH_SAVE     = 8'h73;
  localparam logic [7:0] CH_RESTORE  = 8'h75;
  localparam logic [7:0] CH_ERASE_EOL = 8'h4B;
  localparam logic [7:0] CH_CUP_H    = 8'h48;
  localparam logic [7:0] CH_CUP_F    = 8'h66;
  localparam logic [7:0] CH_CUU      = 8'h41;
  localparam logic [7:0] CH_CUD      = 8'h42;
  localparam logic [7:0] CH_CUF      = 8'h43;
  localparam logic [7:0] CH_CUB      = 8'h44;
  localparam logic [7:0] CH_ED       = 8'h4A;
  localparam logic [7:0] CH_SGR      = 8'h6D;

  localparam logic [ACCUM_W-1:0] ED_ALL      = 14'd2;
  localparam logic [ACCUM_W-1:0] SGR_RESET   = 14'd0;
  localparam logic [ACCUM_W-1:0] SGR_BOLD    = 14'd1;
  localparam logic [ACCUM_W-1:0] SGR_DIM     = 14'd2;
  localparam logic [ACCUM_W-1:0] SGR_BLINK   = 14'd5;
  localparam logic [ACCUM_W-1:0] SGR_FG_LO   = 14'd30;
  localparam logic [ACCUM_W-1:0] SGR_FG_HI   = 14'd37;
  localparam logic [ACCUM_W-1:0] SGR_BG_LO   = 14'd40;
  localparam logic [ACCUM_W-1:0] SGR_BG_HI   = 14'd47;
  localparam logic [7:0] ATTR_BOLD = 8'd8;
  localparam logic [7:0] ATTR_DIM  = 8'd128;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_SET_CURSOR = 4'd1,
    CMD_SET_ROW    = 4'd2,
    CMD_SET_COL    = 4'd3,
    CMD_ERASE      = 4'd4,
    CMD_CLEAR      = 4'd5,
    CMD_FG         = 4'd6,
    CMD_BG         = 4'd7,
    CMD_BLINK      = 4'd8,
    CMD_OR_ATTR    = 4'd9
  } cmd_code_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'b001,
    MODE_BRACKET = 3'b010,
    MODE_PARAMS  = 3'b100
  } parse_mode_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_MASK   = 4'b0100,
    S_SGR    = 4'b1000
  } ctrl_state_t;

  typedef struct packed {
    logic latch_in;
    logic decode_commit;
    logic mask_load;
    logic sgr_emit;
    logic sgr_skip;
    logic none_emit;
  } aecd_cmd_t;

  typedef struct packed {
    logic is_m;
    logic out_free;
    logic mask_zero;
    logic mask_bit;
    logic rest_zero;
  } aecd_sts_t;

  typedef struct packed {
    logic      hit;
    cmd_code_t cmd;
    logic [7:0] value;
  } sgr_res_t;

  function automatic logic [7:0] vga_fg(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd0;
      3'd1: v = 8'd4;
      3'd2: v = 8'd2;
      3'd3: v = 8'd6;
      3'd4: v = 8'd1;
      3'd5: v = 8'd5;
      3'd6: v = 8'd3;
      3'd7: v = 8'd15;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] vga_bg(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd0;
      3'd1: v = 8'd4;
      3'd2: v = 8'd2;
      3'd3: v = 8'd6;
      3'd4: v = 8'd1;
      3'd5: v = 8'd5;
      3'd6: v = 8'd3;
      3'd7: v = 8'd7;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic sgr_res_t sgr_decode(input logic [ACCUM_W-1:0] p);
    sgr_res_t r;
    logic [ACCUM_W-1:0] off_fg;
    logic [ACCUM_W-1:0] off_bg;
    off_fg  = p - SGR_FG_LO;
    off_bg  = p - SGR_BG_LO;
    r.hit   = 1'b1;
    r.cmd   = CMD_NONE;
    r.value = 8'd0;
    if (p == SGR_RESET) begin
      r.cmd = CMD_BLINK;
    end else if (p == SGR_BOLD) begin
      r.cmd   = CMD_OR_ATTR;
      r.value = ATTR_BOLD;
    end else if (p == SGR_DIM) begin
      r.cmd   = CMD_OR_ATTR;
      r.value = ATTR_DIM;
    end else if (p == SGR_BLINK) begin
      r.cmd   = CMD_BLINK;
      r.value = 8'd1;
    end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
      r.cmd   = CMD_FG;
      r.value = vga_fg(off_fg[2:0]);
    end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
      r.cmd   = CMD_BG;
      r.value = vga_bg(off_bg[2:0]);
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

/* design/aecd_datapath.sv */
// datapath: parse state, parameter store, command decode and result register
`timescale 1ns / 1ps

module aecd_datapath import aecd_pkg::*; #(
  parameter int MAX_DIGITS = 4,
  parameter int MAX_PARAMS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  aecd_cmd_t               cmd,
  output aecd_sts_t               sts,
  input  logic [7:0]              byte_in,
  input  logic [7:0]              cursor_row,
  input  logic [7:0]              cursor_col,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_wdata,
  output logic [7:0]              screen_width,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    in_sequence,
  output logic [3:0]              command,
  output logic signed [POS_W-1:0] row,
  output logic signed [POS_W-1:0] col,
  output logic [7:0]              value,
  output logic                    last
);

  localparam int PC_W  = $clog2(MAX_PARAMS + 1);
  localparam int IDX_W = $clog2(MAX_PARAMS);
  localparam int DC_W  = $clog2(MAX_DIGITS + 1);

  logic [7:0] in_byte;
  logic [7:0] in_row;
  logic [7:0] in_col;

  parse_mode_t        mode, mode_next;
  logic [DC_W-1:0]    digit_count, digit_count_next;
  logic [ACCUM_W-1:0] accum_value, accum_value_next;
  logic [PC_W-1:0]    param_count, param_count_next;
  logic [ACCUM_W-1:0] param_store [MAX_PARAMS];
  logic [7:0]         mark_row;
  logic [7:0]         mark_col;
  logic [PC_W-1:0]    sgr_count, sgr_count_next;
  logic [MAX_PARAMS-1:0] sgr_mask, mask_calc, idx_oh, mask_rest;
  logic [IDX_W-1:0]   sgr_idx;

  logic store_we;
  logic save_we;
  logic cnt_lt;
  logic is_digit;
  logic is_letter;
  logic [ACCUM_W-1:0] p0;
  logic [ACCUM_W-1:0] p1;
  logic [POS_W-1:0] crow;
  logic [POS_W-1:0] ccol;
  logic [POS_W-1:0] p0_ext;
  logic [POS_W-1:0] p1_ext;

  logic            dec_seq;
  cmd_code_t       dec_cmd;
  logic [POS_W-1:0] dec_row;
  logic [POS_W-1:0] dec_col;
  logic [7:0]      dec_value;
  logic            dec_is_m;
  sgr_res_t        cur_sgr;
  logic            out_load;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_byte <= byte_in;
      in_row  <= cursor_row;
      in_col  <= cursor_col;
    end
  end

  assign cnt_lt    = param_count < PC_W'(MAX_PARAMS);
  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_letter = ((in_byte >= CH_UP_A) && (in_byte <= CH_UP_Z)) ||
                     ((in_byte >= CH_LO_A) && (in_byte <= CH_LO_Z));
  assign p0     = (param_count == PC_W'(0)) ? accum_value : param_store[0];
  assign p1     = (param_count == PC_W'(1)) ? accum_value : param_store[1];
  assign crow   = {{(POS_W - 8){1'b0}}, in_row};
  assign ccol   = {{(POS_W - 8){1'b0}}, in_col};
  assign p0_ext = {{(POS_W - ACCUM_W){1'b0}}, p0};
  assign p1_ext = {{(POS_W - ACCUM_W){1'b0}}, p1};

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    accum_value_next = accum_value;
    param_count_next = param_count;
    sgr_count_next   = sgr_count;
    store_we         = 1'b0;
    save_we          = 1'b0;
    dec_seq          = 1'b1;
    dec_cmd          = CMD_NONE;
    dec_row          = '0;
    dec_col          = '0;
    dec_value        = 8'd0;
    dec_is_m         = 1'b0;
    case (mode)
      MODE_NORMAL: begin
        if (in_byte == CH_ESC) begin
          mode_next = MODE_BRACKET;
        end else begin
          dec_seq = 1'b0;
        end
      end
      MODE_BRACKET: begin
        if (in_byte == CH_LBRACKET) begin
          mode_next        = MODE_PARAMS;
          param_count_next = '0;
          digit_count_next = '0;
          accum_value_next = '0;
        end else begin
          mode_next = MODE_NORMAL;
          dec_seq   = 1'b0;
        end
      end
      MODE_PARAMS: begin
        if (in_byte == CH_SEMI) begin
          store_we         = cnt_lt;
          param_count_next = cnt_lt ? param_count + PC_W'(1) : param_count;
          digit_count_next = '0;
          accum_value_next = '0;
        end else if (is_digit) begin
          if (digit_count >= DC_W'(MAX_DIGITS)) begin
            mode_next        = MODE_NORMAL;
            param_count_next = '0;
            digit_count_next = '0;
            accum_value_next = '0;
          end else begin
            accum_value_next = accum_value * ACCUM_W'(10) +
                               ACCUM_W'(in_byte - CH_ZERO);
            digit_count_next = digit_count + DC_W'(1);
          end
        end else if (is_letter) begin
          store_we         = cnt_lt;
          sgr_count_next   = cnt_lt ? param_count + PC_W'(1) : param_count;
          mode_next        = MODE_NORMAL;
          param_count_next = '0;
          digit_count_next = '0;
          accum_value_next = '0;
          case (in_byte)
            CH_SAVE: save_we = 1'b1;
            CH_RESTORE: begin
              dec_cmd = CMD_SET_CURSOR;
              dec_row = {{(POS_W - 8){1'b0}}, mark_row};
              dec_col = {{(POS_W - 8){1'b0}}, mark_col};
            end
            CH_ERASE_EOL: begin
              dec_cmd   = CMD_ERASE;
              dec_row   = crow;
              dec_col   = ccol;
              dec_value = screen_width;
            end
            CH_CUP_H, CH_CUP_F: begin
              dec_cmd = CMD_SET_CURSOR;
              dec_row = p0_ext;
              dec_col = p1_ext;
            end
            CH_CUU: begin
              dec_cmd = CMD_SET_ROW;
              dec_row = crow - p0_ext;
              dec_col = ccol;
            end
            CH_CUD: begin
              dec_cmd = CMD_SET_ROW;
              dec_row = crow + p0_ext;
              dec_col = ccol;
            end
            CH_CUF: begin
              dec_cmd = CMD_SET_COL;
              dec_row = crow;
              dec_col = ccol + p0_ext;
            end
            CH_CUB: begin
              dec_cmd = CMD_SET_COL;
              dec_row = crow;
              dec_col = ccol - p0_ext;
            end
            CH_ED: begin
              if (p0 == ED_ALL) begin
                dec_cmd = CMD_CLEAR;
              end
            end
            CH_SGR: dec_is_m = 1'b1;
            default: dec_cmd = CMD_NONE;
          endcase
        end
      end
      default: mode_next = MODE_NORMAL;
    endcase
  end

  // sgr walk: one stored parameter per cycle unless a stalled result register holds an emit
  assign cur_sgr   = sgr_decode(param_store[sgr_idx]);
  assign idx_oh    = {{(MAX_PARAMS - 1){1'b0}}, 1'b1} << sgr_idx;
  assign mask_rest = sgr_mask & ~idx_oh;

  always_comb begin
    sgr_res_t chk;
    chk = '0;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      chk          = sgr_decode(param_store[i]);
      mask_calc[i] = (PC_W'(i) < sgr_count) && chk.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      digit_count <= '0;
      accum_value <= '0;
      param_count <= '0;
      mark_row    <= 8'd0;
      mark_col    <= 8'd0;
      sgr_count   <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        param_store[i] <= '0;
      end
    end else if (cmd.decode_commit) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      accum_value <= accum_value_next;
      param_count <= param_count_next;
      sgr_count   <= sgr_count_next;
      if (store_we) begin
        param_store[param_count[IDX_W-1:0]] <= accum_value;
      end
      if (save_we) begin
        mark_row <= in_row;
        mark_col <= in_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mask_load) begin
      sgr_mask <= mask_calc;
      sgr_idx  <= '0;
    end else if (cmd.sgr_emit || cmd.sgr_skip) begin
      sgr_mask <= mask_rest;
      sgr_idx  <= sgr_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= SCREEN_WIDTH_RESET;
    end else if (cfg_we) begin
      screen_width <= cfg_wdata;
    end
  end

  // result register
  assign out_free = !out_valid || !out_stall;
  assign out_load = (cmd.decode_commit && !dec_is_m) || cmd.sgr_emit || cmd.none_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sgr_emit) begin
      in_sequence <= 1'b1;
      command     <= cur_sgr.cmd;
      row         <= '0;
      col         <= '0;
      value       <= cur_sgr.value;
      last        <= (mask_rest == '0);
    end else if (cmd.none_emit) begin
      in_sequence <= 1'b1;
      command     <= CMD_NONE;
      row         <= '0;
      col         <= '0;
      value       <= 8'd0;
      last        <= 1'b1;
    end else if (out_load) begin
      in_sequence <= dec_seq;
      command     <= dec_cmd;
      row         <= dec_row;
      col         <= dec_col;
      value       <= dec_value;
      last        <= 1'b1;
    end
  end

  assign sts.is_m      = dec_is_m;
  assign sts.out_free  = out_free;
  assign sts.mask_zero = (sgr_mask == '0);
  assign sts.mask_bit  = |(sgr_mask & idx_oh);
  assign sts.rest_zero = (mask_rest == '0);

endmodule

/* design/aecd_ctrl.sv */
// controller: item sequencing and sgr walk state machine
`timescale 1ns / 1ps

module aecd_ctrl import aecd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  aecd_sts_t sts,
  output aecd_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_m) begin
          cmd.decode_commit = 1'b1;
          state_next        = S_MASK;
        end else if (sts.out_free) begin
          cmd.decode_commit = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_MASK: begin
        cmd.mask_load = 1'b1;
        state_next    = S_SGR;
      end
      S_SGR: begin
        if (sts.mask_zero) begin
          if (sts.out_free) begin
            cmd.none_emit = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (sts.mask_bit) begin
          if (sts.out_free) begin
            cmd.sgr_emit = 1'b1;
            if (sts.rest_zero) begin
              state_next = S_IDLE;
            end
          end
        end else begin
          cmd.sgr_skip = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* design/ansi_escape_command_decoder_top.sv */
// top level of the escape command decoder
`timescale 1ns / 1ps

// Takes one text byte per item on the input channel (byte_in with the current
// cursor_row and cursor_col) and returns one or more result items on the
// output channel; last marks the final result of an input item.
// An item is taken at a clock edge with in_valid high and in_stall low, and a
// result is taken with out_valid high and out_stall low.
// The accept edge latches the byte; in the decode state the parse state is
// updated and, once the result register is free, the result is loaded. A
// final 'm' adds a mask state, then walks up to MAX_PARAMS stored parameters
// one per cycle unless a stalled output holds it, with one result per known
// code, or one empty result if none is known. in_stall is high from the accept
// edge until the last result of that item is in the result register; a stalled
// receiver holds the block in that state. screen_width is to be written over
// the APB port at byte address 0 by the user only while the block is idle;
// the block itself does not enforce this. Reads return it, pready is always
// high. Synchronous rst empties the result register, returns parsing to plain
// text, clears the parameter store and saved cursor, sets screen_width to 80.

module ansi_escape_command_decoder_top import aecd_pkg::*; #(
  parameter int MAX_DIGITS = 4,
  parameter int MAX_PARAMS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              byte_in,
  input  logic [7:0]              cursor_row,
  input  logic [7:0]              cursor_col,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    in_sequence,
  output logic [3:0]              command,
  output logic signed [POS_W-1:0] row,
  output logic signed [POS_W-1:0] col,
  output logic [7:0]              value,
  output logic                    last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  aecd_cmd_t  cmd;
  aecd_sts_t  sts;
  logic       cfg_we;
  logic [7:0] screen_width;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SCREEN_WIDTH);
  assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ? {24'd0, screen_width} : 32'd0;

  aecd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  aecd_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .byte_in      (byte_in),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[7:0]),
    .screen_width (screen_width),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .in_sequence  (in_sequence),
    .command      (command),
    .row          (row),
    .col          (col),
    .value        (value),
    .last         (last)
  );

endmodule

/* design/aecd_checker.sv */
// port-level checker of the escape command decoder and its bind
`timescale 1ns / 1ps
`include "ansi_escape_command_decoder_top_assert.svh"

module aecd_checker import aecd_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    in_sequence,
  input logic [3:0]              command,
  input logic signed [POS_W-1:0] row,
  input logic signed [POS_W-1:0] col,
  input logic [7:0]              value,
  input logic                    last,
  input logic                    pready
);

  `AECD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(command) && $stable(row) && $stable(col) && $stable(value) && $stable(last) && $stable(in_sequence), "stalled result item changed")
  `AECD_ASSERT_IMP(a_pready_high, 1'b1, pready, "pready dropped")
  `AECD_ASSERT_IMP(a_print_single, out_valid && !in_sequence, command == CMD_NONE && last, "printed byte with command or more results")
  `AECD_ASSERT_IMP(a_none_empty, out_valid && command == CMD_NONE, row == '0 && col == '0 && value == 8'd0, "empty result with nonzero fields")
  `AECD_ASSERT_IMP(a_attr_no_pos, out_valid && (command == CMD_FG || command == CMD_BG || command == CMD_BLINK || command == CMD_OR_ATTR), row == '0 && col == '0, "attribute result with position")

endmodule

bind ansi_escape_command_decoder_top aecd_checker u_aecd_checker (.*);

/* tb/testbench.sv */
// testbench of the escape command decoder: directed table, random text and escape sequences
`timescale 1ns / 1ps

module testbench import aecd_pkg::*;;

  localparam int MAX_DIGITS = 4;
  localparam int MAX_PARAMS = 8;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [PADDR_W-1:0] WIDTH_ADDR = PADDR_W'({REG_SCREEN_WIDTH, 2'b00});
  localparam logic [63:0] FG_PAL = {8'd15, 8'd3, 8'd5, 8'd1, 8'd6, 8'd2, 8'd4, 8'd0};
  localparam logic [63:0] BG_PAL = {8'd7, 8'd3, 8'd5, 8'd1, 8'd6, 8'd2, 8'd4, 8'd0};

  typedef struct {
    logic                    in_seq;
    cmd_code_t               cmd;
    logic signed [POS_W-1:0] row;
    logic signed [POS_W-1:0] col;
    logic [7:0]              value;
    logic                    last;
  } dec_res_t;

  typedef struct {
    logic [7:0] ch;
    logic [7:0] r;
    logic [7:0] c;
    bit         typed;
    dec_res_t   res;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              byte_in = 8'd0;
  logic [7:0]              cursor_row = 8'd0;
  logic [7:0]              cursor_col = 8'd0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    in_sequence;
  logic [3:0]              command;
  logic signed [POS_W-1:0] row;
  logic signed [POS_W-1:0] col;
  logic [7:0]              value;
  logic                    last;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [31:0]             pwdata = 32'd0;
  logic [31:0]             prdata;
  logic                    pready;

  // decoder state as the testbench sees it
  parse_mode_t        pmode = MODE_NORMAL;
  int                 dcnt = 0;
  logic [ACCUM_W-1:0] accum = '0;
  int                 pcnt = 0;
  logic [ACCUM_W-1:0] pstore [MAX_PARAMS];
  logic [7:0]         saved_r = 8'd0;
  logic [7:0]         saved_c = 8'd0;
  logic [7:0]         scr_width = SCREEN_WIDTH_RESET;

  dec_res_t   step_q[$];
  dec_res_t   expected_q[$];
  dir_row_t   dir_q[$];
  logic [7:0] burst_q[$];
  dec_res_t   got_exp;
  string      fin_set = "suKHfABCDJm";

  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int max_burst = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  ansi_escape_command_decoder_top #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_PARAMS(MAX_PARAMS)
  ) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dec_res_t mk(input logic seq, input cmd_code_t cmd, input int rw,
                                  input int cl, input int val);
    dec_res_t r;
    r.in_seq = seq;
    r.cmd    = cmd;
    r.row    = rw[POS_W-1:0];
    r.col    = cl[POS_W-1:0];
    r.value  = val[7:0];
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void store_param();
    if (pcnt < MAX_PARAMS) begin
      pstore[pcnt] = accum;
      pcnt++;
    end
    dcnt  = 0;
    accum = '0;
  endfunction

  function automatic void end_seq();
    pcnt  = 0;
    dcnt  = 0;
    accum = '0;
    pmode = MODE_NORMAL;
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic [7:0] crow,
                                      input logic [7:0] ccol);
    int                 p0;
    int                 p1;
    int                 cr;
    int                 cc;
    logic [ACCUM_W-1:0] p;
    step_q.delete();
    cr = crow;
    cc = ccol;
    case (pmode)
      MODE_NORMAL: begin
        if (c == CH_ESC) begin
          pmode = MODE_BRACKET;
          step_q.push_back(mk(1'b1, CMD_NONE, 0, 0, 0));
        end else begin
          step_q.push_back(mk(1'b0, CMD_NONE, 0, 0, 0));
        end
      end
      MODE_BRACKET: begin
        if (c == CH_LBRACKET) begin
          pmode = MODE_PARAMS;
          pcnt  = 0;
          dcnt  = 0;
          accum = '0;
          step_q.push_back(mk(1'b1, CMD_NONE, 0, 0, 0));
        end else begin
          pmode = MODE_NORMAL;
          step_q.push_back(mk(1'b0, CMD_NONE, 0, 0, 0));
        end
      end
      default: begin
        if (c == CH_SEMI) begin
          store_param();
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          if (dcnt >= MAX_DIGITS) begin
            end_seq();
          end else begin
            accum = ACCUM_W'(accum * 10 + (c - CH_ZERO));
            dcnt++;
          end
        end else if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
          store_param();
          p0 = pstore[0];
          p1 = pstore[1];
          case (c)
            CH_SAVE: begin
              saved_r = crow;
              saved_c = ccol;
            end
            CH_RESTORE: step_q.push_back(mk(1'b1, CMD_SET_CURSOR, saved_r, saved_c, 0));
            CH_ERASE_EOL: step_q.push_back(mk(1'b1, CMD_ERASE, cr, cc, scr_width));
            CH_CUP_H, CH_CUP_F: step_q.push_back(mk(1'b1, CMD_SET_CURSOR, p0, p1, 0));
            CH_CUU: step_q.push_back(mk(1'b1, CMD_SET_ROW, cr - p0, cc, 0));
            CH_CUD: step_q.push_back(mk(1'b1, CMD_SET_ROW, cr + p0, cc, 0));
            CH_CUF: step_q.push_back(mk(1'b1, CMD_SET_COL, cr, cc + p0, 0));
            CH_CUB: step_q.push_back(mk(1'b1, CMD_SET_COL, cr, cc - p0, 0));
            CH_ED: begin
              if (pstore[0] == ED_ALL) step_q.push_back(mk(1'b1, CMD_CLEAR, 0, 0, 0));
            end
            CH_SGR: begin
              for (int i = 0; i < pcnt; i++) begin
                p = pstore[i];
                if (p == SGR_RESET) begin
                  step_q.push_back(mk(1'b1, CMD_BLINK, 0, 0, 0));
                end else if (p == SGR_BOLD) begin
                  step_q.push_back(mk(1'b1, CMD_OR_ATTR, 0, 0, ATTR_BOLD));
                end else if (p == SGR_DIM) begin
                  step_q.push_back(mk(1'b1, CMD_OR_ATTR, 0, 0, ATTR_DIM));
                end else if (p == SGR_BLINK) begin
                  step_q.push_back(mk(1'b1, CMD_BLINK, 0, 0, 1));
                end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
                  step_q.push_back(mk(1'b1, CMD_FG, 0, 0, FG_PAL[8*(p-SGR_FG_LO) +: 8]));
                end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
                  step_q.push_back(mk(1'b1, CMD_BG, 0, 0, BG_PAL[8*(p-SGR_BG_LO) +: 8]));
                end
              end
            end
            default: ;
          endcase
          end_seq();
        end
        if (step_q.size() == 0) step_q.push_back(mk(1'b1, CMD_NONE, 0, 0, 0));
      end
    endcase
    step_q[step_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [7:0] r, input logic [7:0] c,
                           input bit typed, input dec_res_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_in    <= b;
    cursor_row <= r;
    cursor_col <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, r, c);
    if (step_q.size() > max_burst) max_burst = step_q.size();
    if (typed) begin
      expected_q.push_back(t);
    end else begin
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    end
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(input logic [7:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= {24'd0, w};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scr_width = w;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [7:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WIDTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== w) begin
      mismatches++;
      if (mismatches <= 10) $display("screen_width read: expected %0d got %0d", w, prdata[7:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_typed(input logic [7:0] ch, input logic [7:0] r,
                                    input logic [7:0] c, input logic seq, input cmd_code_t cmd,
                                    input int rw, input int cl, input int val);
    dir_row_t d;
    d.ch  = ch;
    d.r   = r;
    d.c   = c;
    d.typed = 1'b1;
    d.res = mk(seq, cmd, rw, cl, val);
    d.res.last = 1'b1;
    dir_q.push_back(d);
  endfunction

  function automatic void add_pred(input logic [7:0] ch, input logic [7:0] r,
                                   input logic [7:0] c);
    dir_row_t d;
    d.ch  = ch;
    d.r   = r;
    d.c   = c;
    d.typed = 1'b0;
    d.res = mk(1'b0, CMD_NONE, 0, 0, 0);
    dir_q.push_back(d);
  endfunction

  function automatic void push_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) burst_q.push_back(s[i]);
  endfunction

  function automatic int sgr_pick();
    int k;
    k = $urandom_range(0, 23);
    if (k < 4) return (k == 3) ? 5 : k;
    if (k < 12) return 30 + k - 4;
    if (k < 20) return 40 + k - 12;
    return $urandom_range(0, 9999);
  endfunction

  function automatic void build_burst();
    int         kind;
    int         nparams;
    int         sel;
    logic [7:0] fin;
    burst_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 4)) burst_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 2) begin
      burst_q.push_back(CH_ESC);
      burst_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      burst_q.push_back(CH_ESC);
      burst_q.push_back(CH_LBRACKET);
      sel = $urandom_range(0, 12);
      if (sel < 11) fin = fin_set[sel];
      else if (sel == 11) fin = CH_UP_A + 8'($urandom_range(0, 25));
      else fin = CH_LO_A + 8'($urandom_range(0, 25));
      if (fin == CH_SGR) nparams = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 10)
                                                                : $urandom_range(1, 3);
      else nparams = $urandom_range(0, 2);
      for (int i = 0; i < nparams; i++) begin
        if (i > 0) burst_q.push_back(CH_SEMI);
        if ($urandom_range(0, 19) == 0) begin
          burst_q.push_back(($urandom_range(0, 1) == 0) ? 8'h21 + 8'($urandom_range(0, 14))
                                                        : 8'h80 + 8'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 29) == 0) begin
          push_number($urandom_range(10000, 99999));
        end else if (fin == CH_SGR) begin
          push_number(sgr_pick());
        end else begin
          sel = $urandom_range(0, 5);
          if (sel == 0) ;
          else if (sel <= 3) push_number((fin == CH_ED && i == 0) ? ED_ALL
                                                                   : $urandom_range(0, 40));
          else if (sel == 4) push_number($urandom_range(0, 9999));
          else push_number($urandom_range(0, 255));
        end
      end
      burst_q.push_back(fin);
    end
  endfunction

  task automatic run_random(input int target);
    int       start;
    dec_res_t unused;
    start  = items_sent;
    unused = mk(1'b0, CMD_NONE, 0, 0, 0);
    while (items_sent - start < target) begin
      build_burst();
      foreach (burst_q[i]) begin
        send_item(burst_q[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                  unused);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: seq %0b cmd %0d row %0d col %0d value %0d last %0b",
                   in_sequence, command, row, col, value, last);
        end
      end else begin
        got_exp = expected_q.pop_front();
        results_checked++;
        if (in_sequence !== got_exp.in_seq || command !== got_exp.cmd ||
            row !== got_exp.row || col !== got_exp.col ||
            value !== got_exp.value || last !== got_exp.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected seq %0b cmd %0d row %0d col %0d value %0d last %0b",
                     got_exp.in_seq, got_exp.cmd, got_exp.row, got_exp.col, got_exp.value,
                     got_exp.last);
            $display("          got      seq %0b cmd %0d row %0d col %0d value %0d last %0b",
                     in_sequence, command, row, col, value, last);
          end
        end
      end
    end
  end

  // result receiver
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        gap += HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    foreach (pstore[i]) pstore[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_check(SCREEN_WIDTH_RESET);
    apb_write(8'd80);

    add_typed("A", 8'd0, 8'd0, 1'b0, CMD_NONE, 0, 0, 0);
    add_typed(CH_ESC, 8'd255, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed("Q", 8'd0, 8'd255, 1'b0, CMD_NONE, 0, 0, 0);
    add_typed(CH_ESC, 8'd1, 8'd2, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_LBRACKET, 8'd3, 8'd4, 1'b1, CMD_NONE, 0, 0, 0);
    // erase with start column past the line end
    add_typed(CH_ERASE_EOL, 8'd255, 8'd255, 1'b1, CMD_ERASE, 255, 255, 80);
    add_typed(CH_ESC, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_LBRACKET, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    // fifth digit aborts the sequence
    repeat (5) add_typed(CH_NINE, 8'd170, 8'd85, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_ESC, 8'd85, 8'd170, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_LBRACKET, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed("2", 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_ED, 8'd9, 8'd9, 1'b1, CMD_CLEAR, 0, 0, 0);
    // empty first param, stray byte inside params
    add_typed(CH_ESC, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_LBRACKET, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed("!", 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_SEMI, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed("5", 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_pred(CH_CUP_H, 8'd20, 8'd30);
    // second H argument missing, old one reused
    add_pred(CH_ESC, 8'd0, 8'd0);
    add_pred(CH_LBRACKET, 8'd0, 8'd0);
    add_pred("7", 8'd0, 8'd0);
    add_pred(CH_CUP_H, 8'd0, 8'd0);
    // unknown final letter
    add_typed(CH_ESC, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_LBRACKET, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    add_typed(CH_LO_Z, 8'd0, 8'd0, 1'b1, CMD_NONE, 0, 0, 0);
    foreach (dir_q[i]) send_item(dir_q[i].ch, dir_q[i].r, dir_q[i].c, dir_q[i].typed,
                                 dir_q[i].res);
    settle();

    apb_write(8'd255);
    apb_read_check(8'd255);
    run_random(100);
    settle();

    apb_write(8'd1);
    hold_req = 1'b1;
    run_random(100);
    settle();

    apb_write(8'($urandom_range(2, 254)));
    no_gaps = 1'b1;
    run_random(100);
    no_gaps = 1'b0;
    settle();

    apb_write(8'($urandom_range(1, 255)));
    run_random(100);
    settle();

    $display("%0d input items, %0d results checked, up to %0d results from one item",
             items_sent, results_checked, max_burst);
    $display("screen widths 1, 80, 255 and random; one %0d-cycle receiver hold", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
